// ----- src/dns_name_decompressor_unit_defines.svh -----
// assertion macros for the dns name decompressor
`ifndef DNS_NAME_DECOMPRESSOR_UNIT_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DNSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DNSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dnsd_pkg.sv -----
// shared types and constants of the dns name decompressor
`default_nettype none
package dnsd_pkg;
    localparam int TABLE_ENTRIES_DEF     = 16;
    localparam int NAME_BUFFER_DEPTH_DEF = 512;
    localparam int MAX_EMIT              = 512;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_EOF = 2'd1;
    localparam logic [1:0] ST_LTL = 2'd2;
    localparam logic [1:0] ST_NTL = 2'd3;

    localparam logic [0:0] CFG_LABEL_LIMIT = 1'b0;
    localparam logic [0:0] CFG_NAME_LIMIT  = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_push;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } t_direct;
endpackage
`default_nettype wire

// ----- src/dnsd_packer.sv -----
// packs decoded bytes into result words of up to eight characters and passes error and empty-name words through
`default_nettype none
module dnsd_packer import dnsd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_push       i_push,
    input  wire t_direct     i_direct,
    output logic             o_valid,
    output logic [63:0]      o_name_chars,
    output logic [3:0]       o_char_count,
    output logic [1:0]       o_status,
    output logic             o_last_chunk
);
    logic [63:0] r_chunk;
    logic [2:0]  r_cnt;
    logic [63:0] n_chunk;

    assign n_chunk = r_chunk | (64'(i_push.data) << (6'(r_cnt) * 6'd8));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_cnt   <= 3'd0;
            r_chunk <= 64'd0;
        end else begin
            o_valid <= 1'b0;
            if (i_direct.valid) begin
                o_valid      <= 1'b1;
                o_name_chars <= 64'd0;
                o_char_count <= 4'd0;
                o_status     <= i_direct.status;
                o_last_chunk <= 1'b1;
            end else if (i_push.valid) begin
                if (r_cnt == 3'd7 || i_push.last) begin
                    o_valid      <= 1'b1;
                    o_name_chars <= n_chunk;
                    o_char_count <= 4'(r_cnt) + 4'd1;
                    o_status     <= ST_OK;
                    o_last_chunk <= i_push.last;
                    r_cnt        <= 3'd0;
                    r_chunk      <= 64'd0;
                end else begin
                    r_cnt   <= r_cnt + 3'd1;
                    r_chunk <= n_chunk;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/dns_name_decompressor_unit.sv -----
// dns name decompressor: label decode, name table and chunked name output
// label and length bytes: accepted one per cycle, busy stays low
// name end or pointer: busy through a scan of all TABLE_ENTRIES table entries, a decision state,
// then one emitted character per cycle through the name buffer and stored-name read ports
// byte-level errors: one word the cycle after the byte; empty names, pointer errors: after scan
// reset (synchronous, active low) empties the name table and returns to length phase
// results come as one-cycle strobes on o_valid; the receiver cannot stall them
`default_nettype none
module dns_name_decompressor_unit import dnsd_pkg::*; #(
    parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
    parameter int NAME_BUFFER_DEPTH = NAME_BUFFER_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_position,
    input  wire logic        i_name_start,
    input  wire logic        i_message_start,
    input  wire logic        i_stream_end,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [8:0]  i_cfg_data,
    output logic             o_valid,
    output logic [63:0]      o_name_chars,
    output logic [3:0]       o_char_count,
    output logic [1:0]       o_status,
    output logic             o_last_chunk
);
`include "dns_name_decompressor_unit_defines.svh"

    localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int NAW = $clog2(NAME_BUFFER_DEPTH);
    localparam int NLW = $clog2(NAME_BUFFER_DEPTH + 1);
    localparam int LW  = NLW + 1;
    localparam int TCD = TABLE_ENTRIES * NAME_BUFFER_DEPTH;
    localparam int TAW = (TCD > 1) ? $clog2(TCD) : 1;

    // decoder phase
    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_LABEL = 2'd1;
    localparam logic [1:0] PH_PTR   = 2'd2;
    localparam logic [1:0] PH_IDLE  = 2'd3;
    // sequencer state
    localparam logic [1:0] S_IN   = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // configuration
    logic [7:0] r_label_limit;
    logic [8:0] r_name_limit;

    // decoder state
    logic [1:0]     r_phase;
    logic [7:0]     r_lrem;
    logic [5:0]     r_ptr_hi;
    logic [15:0]    r_nsp;
    logic [NLW-1:0] r_nlen;
    logic [1:0]     r_st;

    // pending dot write after a label end
    logic           r_dot_pend;
    logic [NAW-1:0] r_dot_addr;

    // table scan
    logic           r_is_ptr;
    logic [15:0]    r_key;
    logic [IW-1:0]  r_idx;
    logic           r_hit;
    logic [IW-1:0]  r_hit_idx;
    logic           r_free;
    logic [IW-1:0]  r_free_idx;

    // table directory in flops
    logic [TABLE_ENTRIES-1:0] r_tv;
    logic [15:0]              r_tk [TABLE_ENTRIES];
    logic [NLW-1:0]           r_tl [TABLE_ENTRIES];

    // emission walk
    logic [LW-1:0]  r_j;
    logic [LW-1:0]  r_tot;
    logic [LW-1:0]  r_pre;
    logic [TAW-1:0] r_base;
    logic           r_ins;
    logic           r_rdv;
    logic           r_rd_last;
    logic           r_rd_src;
    logic [TAW-1:0] r_wa;

    // memories
    logic [7:0] nb_mem [NAME_BUFFER_DEPTH];
    logic [7:0] tc_mem [TCD];
    logic [7:0] nb_q;
    logic [7:0] tc_q;

    logic           acc;
    logic [1:0]     ph_e;
    logic [NLW-1:0] nlen_e;
    logic [7:0]     lrem_e;
    logic [5:0]     ptr_hi_e;
    logic [15:0]    nsp_e;
    logic [NLW-1:0] nl1;
    logic [NLW-1:0] nl2;
    logic [7:0]     lrem_dec;

    logic           nb_we;
    logic [NAW-1:0] nb_wa;
    logic [7:0]     nb_wd;
    logic [7:0]     rd_byte;
    logic           tc_we;
    logic           issue;
    logic           from_nb;

    logic [NLW-1:0] slen;
    logic [LW-1:0]  pre_adj;
    logic [LW-1:0]  sum;

    t_push   push;
    t_direct direct;

    assign busy = (r_st != S_IN);
    assign acc  = start && !busy;

    // fields as seen after a name restart
    assign ph_e     = i_name_start ? PH_LEN : r_phase;
    assign nlen_e   = i_name_start ? '0 : r_nlen;
    assign lrem_e   = i_name_start ? 8'd0 : r_lrem;
    assign ptr_hi_e = i_name_start ? 6'd0 : r_ptr_hi;
    assign nsp_e    = i_name_start ? i_position : r_nsp;

    // saturating appends of the label byte and of the dot
    assign nl1      = (nlen_e < NLW'(NAME_BUFFER_DEPTH)) ? nlen_e + 1'b1 : nlen_e;
    assign nl2      = (nl1 < NLW'(NAME_BUFFER_DEPTH)) ? nl1 + 1'b1 : nl1;
    assign lrem_dec = lrem_e - 8'd1;

    // buffer write port: label bytes, then the dot in the following cycle
    always_comb begin
        nb_we = 1'b0;
        nb_wa = nlen_e[NAW-1:0];
        nb_wd = i_data_byte;
        if (r_dot_pend) begin
            nb_we = 1'b1;
            nb_wa = r_dot_addr;
            nb_wd = 8'h2E;
        end else if (acc && !i_stream_end && ph_e == PH_LABEL &&
                     nlen_e < NLW'(NAME_BUFFER_DEPTH)) begin
            nb_we = 1'b1;
        end
    end

    // pointer decision terms
    assign slen    = r_tl[r_hit_idx];
    assign pre_adj = (slen == '0 && r_pre != '0) ? r_pre - 1'b1 : r_pre;
    assign sum     = pre_adj + LW'(slen);

    assign issue   = (r_st == S_EMIT) && (r_j < r_tot);
    assign from_nb = (r_j < r_pre);
    assign rd_byte = r_rd_src ? tc_q : nb_q;
    // copy into a fresh table slot rides along with the emission
    assign tc_we   = r_rdv && r_ins && !r_rd_src;

    assign push.valid = r_rdv;
    assign push.data  = rd_byte;
    assign push.last  = r_rd_last;

    // error and empty-name results bypass the byte walk
    always_comb begin
        direct.valid  = 1'b0;
        direct.status = ST_OK;
        if (acc) begin
            if (i_stream_end) begin
                direct.valid  = (ph_e != PH_IDLE);
                direct.status = ST_EOF;
            end else begin
                case (ph_e)
                    PH_LEN: begin
                        if (i_data_byte != 8'd0 && i_data_byte[7:6] != 2'b11 &&
                            i_data_byte > r_label_limit) begin
                            direct.valid  = 1'b1;
                            direct.status = ST_LTL;
                        end
                    end
                    PH_LABEL: begin
                        if (lrem_dec == 8'd0 &&
                            (LW'(nl2) >= LW'(r_name_limit) ||
                             nl2 >= NLW'(NAME_BUFFER_DEPTH))) begin
                            direct.valid  = 1'b1;
                            direct.status = ST_NTL;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (r_st == S_DEC) begin
            if (!r_is_ptr) begin
                direct.valid = (r_tot == '0);
            end else if (!r_hit) begin
                direct.valid  = 1'b1;
                direct.status = ST_LTL;
            end else if (sum >= LW'(r_name_limit)) begin
                direct.valid  = 1'b1;
                direct.status = ST_NTL;
            end else begin
                direct.valid = (sum == '0);
            end
        end
    end

    // name buffer memory
    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            nb_mem[nb_wa] <= nb_wd;
        end
        nb_q <= nb_mem[r_j[NAW-1:0]];
    end

    // stored name characters memory
    always_ff @(posedge i_clk) begin
        if (tc_we) begin
            tc_mem[r_wa] <= rd_byte;
        end
        tc_q <= tc_mem[r_base + TAW'(r_j - r_pre)];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_limit <= 8'd64;
            r_name_limit  <= 9'd257;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LABEL_LIMIT: r_label_limit <= i_cfg_data[7:0];
                CFG_NAME_LIMIT:  r_name_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decoder and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN;
            r_lrem     <= 8'd0;
            r_ptr_hi   <= 6'd0;
            r_nsp      <= 16'd0;
            r_nlen     <= '0;
            r_st       <= S_IN;
            r_dot_pend <= 1'b0;
            r_tv       <= '0;
            r_rdv      <= 1'b0;
            r_ins      <= 1'b0;
        end else begin
            r_dot_pend <= 1'b0;
            r_rdv      <= 1'b0;
            case (r_st)
                S_IN: begin
                    if (acc) begin
                        if (i_message_start) begin
                            r_tv <= '0;
                        end
                        r_phase  <= ph_e;
                        r_nlen   <= nlen_e;
                        r_lrem   <= lrem_e;
                        r_ptr_hi <= ptr_hi_e;
                        r_nsp    <= nsp_e;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_free   <= 1'b0;
                        if (i_stream_end) begin
                            r_phase <= PH_IDLE;
                        end else begin
                            case (ph_e)
                                PH_LEN: begin
                                    if (i_data_byte == 8'd0) begin
                                        // name end: drop the trailing dot, go look up the key
                                        r_key    <= nsp_e;
                                        r_tot    <= (nlen_e != '0) ? LW'(nlen_e) - 1'b1 : '0;
                                        r_is_ptr <= 1'b0;
                                        r_phase  <= PH_IDLE;
                                        r_st     <= S_SCAN;
                                    end else if (i_data_byte[7:6] == 2'b11) begin
                                        r_ptr_hi <= i_data_byte[5:0];
                                        r_phase  <= PH_PTR;
                                    end else if (i_data_byte > r_label_limit) begin
                                        r_phase <= PH_IDLE;
                                    end else begin
                                        r_lrem  <= i_data_byte;
                                        r_phase <= PH_LABEL;
                                    end
                                end
                                PH_LABEL: begin
                                    r_lrem <= lrem_dec;
                                    r_nlen <= nl1;
                                    if (lrem_dec == 8'd0) begin
                                        r_nlen     <= nl2;
                                        r_dot_pend <= (nl1 < NLW'(NAME_BUFFER_DEPTH));
                                        r_dot_addr <= nl1[NAW-1:0];
                                        if (direct.valid) begin
                                            r_phase <= PH_IDLE;
                                        end else begin
                                            r_phase <= PH_LEN;
                                        end
                                    end
                                end
                                PH_PTR: begin
                                    r_key    <= {2'b00, ptr_hi_e, i_data_byte};
                                    r_pre    <= LW'(nlen_e);
                                    r_is_ptr <= 1'b1;
                                    r_phase  <= PH_IDLE;
                                    r_st     <= S_SCAN;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    // one directory entry per cycle: first match and first free slot
                    if (r_tv[r_idx] && r_tk[r_idx] == r_key && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                    end
                    if (!r_tv[r_idx] && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                    if (r_idx == IW'(TABLE_ENTRIES - 1)) begin
                        r_st <= S_DEC;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DEC: begin
                    r_j  <= '0;
                    r_st <= S_IN;
                    if (!r_is_ptr) begin
                        r_pre <= r_tot;
                        r_ins <= 1'b0;
                        if (!r_hit && r_free) begin
                            r_tv[r_free_idx] <= 1'b1;
                            r_tk[r_free_idx] <= r_key;
                            r_tl[r_free_idx] <= NLW'(r_tot);
                            r_ins            <= 1'b1;
                            r_base           <= TAW'(32'(r_free_idx) * NAME_BUFFER_DEPTH);
                        end
                        if (r_tot != '0) begin
                            r_st <= S_EMIT;
                        end
                    end else if (r_hit && !direct.valid) begin
                        r_pre  <= pre_adj;
                        r_tot  <= (sum > LW'(MAX_EMIT)) ? LW'(MAX_EMIT) : sum;
                        r_base <= TAW'(32'(r_hit_idx) * NAME_BUFFER_DEPTH);
                        r_ins  <= 1'b0;
                        r_st   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        r_rdv     <= 1'b1;
                        r_rd_last <= (r_j == r_tot - 1'b1);
                        r_rd_src  <= !from_nb;
                        r_wa      <= r_base + TAW'(r_j);
                        r_j       <= r_j + 1'b1;
                    end
                    if (r_rdv && r_rd_last) begin
                        r_ins <= 1'b0;
                        r_st  <= S_IN;
                    end
                end
                default: r_st <= S_IN;
            endcase
        end
    end

    dnsd_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_direct     (direct),
        .o_valid      (o_valid),
        .o_name_chars (o_name_chars),
        .o_char_count (o_char_count),
        .o_status     (o_status),
        .o_last_chunk (o_last_chunk)
    );

    // result words other than the last of a name carry eight characters
    `DNSD_ASSERT_NOW(a_full_chunk, o_valid && !o_last_chunk, o_char_count == 4'd8 && o_status == ST_OK, "short non-final chunk")
    // error words carry no characters and end the name
    `DNSD_ASSERT_NOW(a_err_word, o_valid && o_status != ST_OK, o_char_count == 4'd0 && o_last_chunk, "malformed error word")
    // a byte taken at name end always leads into the table scan
    `DNSD_ASSERT_NEXT(a_scan_after_end, acc && !i_stream_end && ph_e == PH_LEN && i_data_byte == 8'd0, r_st == S_SCAN, "no table scan at name end")
endmodule
`default_nettype wire

// ----- tb/tb_dns_name_decompressor_unit.sv -----
// self-checking testbench for the dns name decompressor unit
`default_nettype none
module tb_dns_name_decompressor_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dnsd_pkg::*;

    localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int BUF_DEPTH = NAME_BUFFER_DEPTH_DEF;
    // table scan, decision and spare margin, used as a settle time when idle
    localparam int SETTLE    = N_ENTRIES + 24;

    typedef enum logic [1:0] {DEC_LEN, DEC_LABEL, DEC_PTR, DEC_IDLE} t_dec_phase;

    typedef struct {
        logic [7:0]  data;
        logic [15:0] pos;
        logic        nstart;
        logic        mstart;
        logic        send;
    } t_byte_word;

    typedef struct {
        logic [63:0] chars;
        logic [3:0]  count;
        logic [1:0]  status;
        logic        last;
    } t_name_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_data_byte = '0;
    logic [15:0] i_position = '0;
    logic        i_name_start = 1'b0;
    logic        i_message_start = 1'b0;
    logic        i_stream_end = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = CFG_LABEL_LIMIT;
    logic [8:0]  i_cfg_data = '0;
    logic        o_valid;
    logic [63:0] o_name_chars;
    logic [3:0]  o_char_count;
    logic [1:0]  o_status;
    logic        o_last_chunk;

    dns_name_decompressor_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data_byte(i_data_byte), .i_position(i_position),
        .i_name_start(i_name_start), .i_message_start(i_message_start),
        .i_stream_end(i_stream_end), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_name_chars(o_name_chars),
        .o_char_count(o_char_count), .o_status(o_status), .o_last_chunk(o_last_chunk)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor state: its own copy of the decoder and the name table
    // ---------------------------------------------------------------
    logic [7:0]  lim_label = 8'd64;
    logic [8:0]  lim_name  = 9'd257;
    t_dec_phase  dec_phase = DEC_LEN;
    logic [7:0]  lbl_left  = '0;
    logic [5:0]  ptr_hi    = '0;
    logic [15:0] cur_key   = '0;
    int          buf_len   = 0;
    logic [7:0]  name_buf [BUF_DEPTH];
    logic        tbl_valid [N_ENTRIES];
    logic [15:0] tbl_key [N_ENTRIES];
    int          tbl_len [N_ENTRIES];
    logic [7:0]  tbl_chars [N_ENTRIES][BUF_DEPTH];
    logic [7:0]  joined [2*BUF_DEPTH];

    t_name_word  expected_words[$];
    t_byte_word  pending_bytes[$];
    bit          errors = 0;

    initial foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

    function automatic void expect_error(logic [1:0] code);
        t_name_word w;
        w.chars = '0; w.count = '0; w.status = code; w.last = 1'b1;
        expected_words.insert(expected_words.size(), w);
        dec_phase = DEC_IDLE;
    endfunction

    // split a decoded name into eight-character words
    function automatic void expect_name(bit from_joined, int len);
        t_name_word w;
        int nw;
        int cnt;
        if (len > 512) len = 512;
        nw = (len + 7) / 8;
        if (nw == 0) begin
            w.chars = '0; w.count = '0; w.status = ST_OK; w.last = 1'b1;
            expected_words.insert(expected_words.size(), w);
        end
        for (int k = 0; k < nw; k++) begin
            cnt = len - k*8;
            if (cnt > 8) cnt = 8;
            w.chars = '0;
            for (int i = 0; i < cnt; i++)
                w.chars[8*i +: 8] = from_joined ? joined[k*8+i] : name_buf[k*8+i];
            w.count = cnt[3:0];
            w.status = ST_OK;
            w.last = (k + 1 == nw);
            expected_words.insert(expected_words.size(), w);
        end
    endfunction

    function automatic int lookup_key(logic [15:0] key);
        for (int i = 0; i < N_ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == key) return i;
        return -1;
    endfunction

    function automatic void push_char(logic [7:0] c);
        if (buf_len < BUF_DEPTH) begin
            name_buf[buf_len] = c;
            buf_len++;
        end
    endfunction

    function automatic void decode_byte(t_byte_word it);
        int len;
        int e;
        int pre;
        int slen;
        if (it.mstart) foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        if (it.nstart) begin
            dec_phase = DEC_LEN; buf_len = 0; lbl_left = '0; ptr_hi = '0;
            cur_key = it.pos;
        end
        if (it.send) begin
            if (dec_phase != DEC_IDLE) expect_error(ST_EOF);
            return;
        end
        case (dec_phase)
            DEC_LEN: begin
                if (it.data == 8'h00) begin
                    len = buf_len > 0 ? buf_len - 1 : 0;
                    // store only under a new key and only while a slot is free
                    if (lookup_key(cur_key) < 0) begin
                        for (int i = 0; i < N_ENTRIES; i++) begin
                            if (!tbl_valid[i]) begin
                                for (int j = 0; j < len; j++) tbl_chars[i][j] = name_buf[j];
                                tbl_len[i] = len; tbl_key[i] = cur_key;
                                tbl_valid[i] = 1'b1;
                                break;
                            end
                        end
                    end
                    dec_phase = DEC_IDLE;
                    expect_name(0, len);
                end else if (it.data[7:6] == 2'b11) begin
                    ptr_hi = it.data[5:0];
                    dec_phase = DEC_PTR;
                end else if (it.data > lim_label) begin
                    expect_error(ST_LTL);
                end else begin
                    lbl_left = it.data;
                    dec_phase = DEC_LABEL;
                end
            end
            DEC_LABEL: begin
                push_char(it.data);
                lbl_left--;
                if (lbl_left == 0) begin
                    push_char(8'h2E);
                    if (buf_len >= lim_name || buf_len >= BUF_DEPTH) expect_error(ST_NTL);
                    else dec_phase = DEC_LEN;
                end
            end
            DEC_PTR: begin
                e = lookup_key({2'b00, ptr_hi, it.data});
                dec_phase = DEC_IDLE;
                if (e < 0) begin
                    expect_error(ST_LTL);
                end else begin
                    slen = tbl_len[e];
                    pre = buf_len;
                    // pointer to the root name drops the prefix's trailing dot
                    if (slen == 0 && pre > 0) pre--;
                    if (pre + slen >= lim_name) begin
                        expect_error(ST_NTL);
                    end else begin
                        for (int j = 0; j < pre; j++) joined[j] = name_buf[j];
                        for (int j = 0; j < slen; j++) joined[pre+j] = tbl_chars[e][j];
                        expect_name(1, pre + slen);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // driver: feeds bytes from the pending queue; gaps_on adds random gaps
    // ---------------------------------------------------------------
    bit         gaps_on = 1;
    int         gap_left = 0;
    t_byte_word cur_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (!(start && busy)) begin
            if (start) decode_byte(cur_word);   // word accepted at this edge
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_bytes.size() > 0) begin
                if (gaps_on && $urandom_range(0, 11) == 0) begin
                    start <= 1'b0;
                    gap_left <= $urandom_range(0, 15);
                end else begin
                    cur_word = pending_bytes.pop_front();
                    i_data_byte <= cur_word.data;
                    i_position <= cur_word.pos;
                    i_name_start <= cur_word.nstart;
                    i_message_start <= cur_word.mstart;
                    i_stream_end <= cur_word.send;
                    start <= 1'b1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: every strobed word must match the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_name_word w;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word chars=%h count=%0d status=%0d last=%0d",
                         $realtime, o_name_chars, o_char_count, o_status, o_last_chunk);
                errors = 1;
            end else begin
                w = expected_words.pop_front();
                if (o_name_chars !== w.chars) begin
                    $display("%0t: name_chars expected %h actual %h",
                             $realtime, w.chars, o_name_chars);
                    errors = 1;
                end
                if (o_char_count !== w.count) begin
                    $display("%0t: char_count expected %0d actual %0d",
                             $realtime, w.count, o_char_count);
                    errors = 1;
                end
                if (o_status !== w.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, w.status, o_status);
                    errors = 1;
                end
                if (o_last_chunk !== w.last) begin
                    $display("%0t: last_chunk expected %0d actual %0d",
                             $realtime, w.last, o_last_chunk);
                    errors = 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    int          msg_pos = 0;
    logic [15:0] known_keys[$];

    function automatic void put_byte(logic [7:0] d, logic [15:0] p, bit ns = 0,
                                     bit ms = 0, bit se = 0);
        t_byte_word it;
        it.data = d; it.pos = p; it.nstart = ns; it.mstart = ms; it.send = se;
        pending_bytes.insert(pending_bytes.size(), it);
    endfunction

    // next byte of the current message, first-byte flags as given
    function automatic void msg_byte(logic [7:0] d, bit ns = 0, bit ms = 0, bit se = 0);
        put_byte(d, msg_pos[15:0], ns, ms, se);
        msg_pos++;
    endfunction

    // one encoded name with random labels and a random ending
    function automatic void random_name(bit new_msg);
        int nlab;
        int llen;
        int r;
        bit first;
        if (new_msg) begin
            known_keys.delete();
            // some messages sit high so pointer keys reach the top bits
            msg_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'h3E00) : 0;
        end
        known_keys.insert(known_keys.size(), msg_pos[15:0]);
        first = 1;
        nlab = $urandom_range(0, 4);
        for (int l = 0; l < nlab; l++) begin
            r = $urandom_range(0, 15);
            if (r == 0) llen = $urandom_range(1, 255);
            else if (r == 1) llen = lim_label;
            else llen = $urandom_range(1, 8);
            if (llen == 0) llen = 1;
            msg_byte(llen[7:0], first, first && new_msg);
            first = 0;
            if (llen > lim_label) return;   // rejected length, no label follows
            // sometimes cut the name short; the next name start restarts
            if ($urandom_range(0, 24) == 0) return;
            for (int c = 0; c < llen; c++) msg_byte(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 19);
        if (r < 11) begin
            msg_byte(8'h00, first, first && new_msg);
        end else if (r < 16 && known_keys.size() > 1) begin
            r = known_keys[$urandom_range(0, known_keys.size() - 2)];
            msg_byte({2'b11, r[13:8]}, first, first && new_msg);
            msg_byte(r[7:0]);
        end else if (r < 18) begin
            msg_byte({2'b11, 6'($urandom_range(0, 63))}, first, first && new_msg);
            msg_byte(8'($urandom_range(0, 255)));
        end else begin
            msg_byte(8'($urandom_range(0, 255)), first, first && new_msg, 1'b1);
        end
        // idle bytes and idle stream ends after the name
        if ($urandom_range(0, 5) == 0)
            put_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 0,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || start || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_LABEL_LIMIT) lim_label = val[7:0];
        else lim_name = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n_words);
        int start_cnt;
        start_cnt = pending_bytes.size();
        random_name(1);
        while (pending_bytes.size() - start_cnt < n_words)
            random_name($urandom_range(0, 7) == 0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset limits, table hits and misses, label-too-long and end-of-stream errors
        msg_pos = 0;
        msg_byte(8'd2, 1, 1); msg_byte("a"); msg_byte("b");
        msg_byte(8'd1); msg_byte("c"); msg_byte(8'h00);           // stored at 0
        msg_byte(8'd1, 1); msg_byte("x"); msg_byte(8'hC0); msg_byte(8'h00); // prefix + hit
        msg_byte(8'h00, 1);                                        // empty name at 10
        msg_byte(8'd1, 1); msg_byte("y"); msg_byte(8'hC0); msg_byte(8'd10); // root pointer
        msg_byte(8'hFF, 1); msg_byte(8'hFF);                       // unresolved pointer
        msg_byte(8'h41, 1);                                        // label too long
        msg_byte(8'h80, 1);                                        // reserved flags 10
        msg_byte(8'd3, 1); msg_byte("q");
        msg_byte(8'd1, 1); msg_byte(8'h00, 0, 0, 1);               // restart, then eof
        put_byte(8'hFF, 16'hFFFF, 0, 0, 1);                        // idle stream end
        put_byte(8'h00, 16'hFFFF, 0, 1, 0);                        // idle byte
        random_phase(100);
        wait_idle();

        write_cfg(CFG_LABEL_LIMIT, 9'd255);
        write_cfg(CFG_NAME_LIMIT, 9'd320);
        random_phase(140);
        wait_idle();

        write_cfg(CFG_LABEL_LIMIT, 9'd0);
        write_cfg(CFG_NAME_LIMIT, 9'd1);
        random_phase(40);
        wait_idle();

        write_cfg(CFG_LABEL_LIMIT, 9'd6);
        write_cfg(CFG_NAME_LIMIT, 9'd20);
        random_phase(100);
        wait_idle();

        // last part without gaps
        write_cfg(CFG_LABEL_LIMIT, 9'($urandom_range(0, 255)));
        write_cfg(CFG_NAME_LIMIT, 9'($urandom_range(1, 320)));
        gaps_on = 0;
        random_phase(80);
        wait_idle();

        if (!errors) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+src
src/dnsd_pkg.sv
src/dnsd_packer.sv
src/dns_name_decompressor_unit.sv
tb/tb_dns_name_decompressor_unit.sv
